FILE: design/sitp_pkg.sv
// Shared types, widths and codes of the strict integer text parser.
package sitp_pkg;

  localparam int CHAR_W        = 8;
  localparam int VALUE_W       = 64;
  localparam int COUNT_W       = 16;
  localparam int STATUS_W      = 2;
  localparam int BASE_W        = 6;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 64;
  localparam int MAX_TEXT_LENGTH = 65535;
  localparam int MAX_BASE      = 36;
  localparam int RESET_BASE    = 10;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_BASE = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_LIMIT = 1'd1;

  // One classified character as it travels from the front to the back.
  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              digit_ok;
    logic              is_zero;
    logic              is_x;
    logic              is_oct;
    logic              is_hex;
    logic              has_char;
    logic              last;
  } sitp_class_t;

endpackage

FILE: design/sitp_text_if.sv
// Character input channel.
interface sitp_text_if import sitp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              has_char;
  logic              end_of_text;

  modport source (output valid, character, has_char, end_of_text, input ready);
  modport sink (input valid, character, has_char, end_of_text, output ready);
endinterface

FILE: design/sitp_result_if.sv
// Parse result output channel.
interface sitp_result_if import sitp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  parsed_value;
  logic [COUNT_W-1:0]  chars_consumed;
  logic [STATUS_W-1:0] parse_status;

  modport source (output valid, parsed_value, chars_consumed, parse_status, input ready);
  modport sink (input valid, parsed_value, chars_consumed, parse_status, output ready);
endinterface

FILE: design/sitp_cfg_if.sv
// Configuration register write channel.
interface sitp_cfg_if import sitp_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/sitp_front.sv
// Front end: accepts characters and classifies them as digits and prefix marks.
module sitp_front import sitp_pkg::*; (
  sitp_text_if.sink   text,
  output sitp_class_t cls,
  output logic        cls_valid,
  input  logic        cls_ready
);

  logic [CHAR_W-1:0] c;
  logic [BASE_W-1:0] digit;
  logic              digit_ok;

  assign c = text.character;

  always_comb begin
    digit    = '0;
    digit_ok = 1'b0;
    priority if (c >= 8'h30 && c <= 8'h39) begin
      digit    = BASE_W'(c - 8'h30);
      digit_ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      digit    = BASE_W'(c - 8'h57);
      digit_ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      digit    = BASE_W'(c - 8'h37);
      digit_ok = 1'b1;
    end
  end

  always_comb begin
    cls.digit    = digit;
    cls.digit_ok = digit_ok;
    cls.is_zero  = (c == 8'h30);
    cls.is_x     = (c == 8'h78);
    cls.is_oct   = digit_ok && (digit < BASE_W'(8));
    cls.is_hex   = digit_ok && (digit < BASE_W'(16));
    cls.has_char = text.has_char;
    cls.last     = text.end_of_text;
  end

  assign cls_valid  = text.valid;
  assign text.ready = cls_ready;

endmodule

FILE: design/sitp_queue.sv
// Two-entry queue of classified words between the front and the back.
module sitp_queue import sitp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sitp_class_t push_data,
  input  logic        push_valid,
  output logic        push_ready,
  output sitp_class_t pop_data,
  output logic        pop_valid,
  input  logic        pop
);

  sitp_class_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/sitp_back.sv
// Back end: prefix handling, multiply-and-add per digit, result forming and output.
module sitp_back import sitp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  sitp_class_t   q_data,
  input  logic          q_valid,
  output logic          q_pop,
  sitp_cfg_if.sink      cfg,
  sitp_result_if.source result
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_AUTO  = 3'd1;
  localparam logic [2:0] PH_SAW0  = 3'd2;
  localparam logic [2:0] PH_SAW0X = 3'd3;
  localparam logic [2:0] PH_RUN   = 3'd4;
  localparam logic [2:0] PH_BAD   = 3'd5;

  localparam logic [BASE_W-1:0] BASE_8  = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_10 = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_16 = BASE_W'(16);
  localparam int PROD_W = VALUE_W + BASE_W;

  logic [BASE_W-1:0]  number_base;
  logic [VALUE_W-1:0] result_limit;

  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic               overflow_seen, overflow_seen_next;
  logic               parse_stopped, parse_stopped_next;
  logic [BASE_W-1:0]  active_base, active_base_next;
  logic [2:0]         prefix_phase, prefix_phase_next;
  logic [COUNT_W-1:0] char_position, char_position_next;
  logic [COUNT_W-1:0] stop_position, stop_position_next;

  logic [2:0]         eff_phase;
  logic [BASE_W-1:0]  eff_base;
  logic               take_char;
  logic               run_en;
  logic [BASE_W-1:0]  run_base;
  logic               digit_in;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W:0]   sum;
  logic [COUNT_W-1:0] consumed;
  logic               go;

  logic               fin_valid;
  logic [VALUE_W-1:0] fin_acc;
  logic               fin_ovf;
  logic               fin_bad;
  logic [COUNT_W-1:0] fin_consumed;
  logic               fin_free;
  logic               out_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base  <= BASE_W'(RESET_BASE);
      result_limit <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_NUMBER_BASE:  number_base  <= cfg.data[BASE_W-1:0];
        CFG_RESULT_LIMIT: result_limit <= cfg.data;
        default:          result_limit <= result_limit;
      endcase
    end
  end

  assign out_load = fin_valid && (!result.valid || result.ready);
  assign fin_free = !fin_valid || out_load;
  assign go       = q_valid && (!q_data.last || fin_free);
  assign q_pop    = go;

  always_comb begin
    if (prefix_phase == PH_START) begin
      eff_base = number_base;
      if (number_base > BASE_W'(MAX_BASE)) begin
        eff_phase = PH_BAD;
      end else if (number_base == '0) begin
        eff_phase = PH_AUTO;
      end else begin
        eff_phase = PH_RUN;
      end
    end else begin
      eff_base  = active_base;
      eff_phase = prefix_phase;
    end
  end

  assign prod     = PROD_W'(accumulator) * PROD_W'(run_base);
  assign sum      = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(q_data.digit);
  assign digit_in = q_data.digit_ok && (q_data.digit < run_base);
  assign take_char = q_data.has_char && (char_position < COUNT_W'(MAX_TEXT_LENGTH));

  always_comb begin
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    parse_stopped_next = parse_stopped;
    active_base_next   = eff_base;
    prefix_phase_next  = eff_phase;
    char_position_next = char_position;
    stop_position_next = stop_position;
    run_en             = 1'b0;
    run_base           = eff_base;

    if (take_char) begin
      char_position_next = char_position + COUNT_W'(1);
      unique case (eff_phase)
        PH_AUTO: begin
          if (q_data.is_zero) begin
            prefix_phase_next = PH_SAW0;
          end else begin
            run_en = 1'b1;
            run_base = BASE_10;
          end
        end
        PH_SAW0: begin
          priority if (q_data.is_oct) begin
            run_en = 1'b1;
            run_base = BASE_8;
          end else if (q_data.is_x) begin
            prefix_phase_next = PH_SAW0X;
          end else begin
            run_en = 1'b1;
            run_base = BASE_10;
          end
        end
        PH_SAW0X: begin
          if (q_data.is_hex) begin
            run_en = 1'b1;
            run_base = BASE_16;
          end else begin
            active_base_next   = BASE_10;
            prefix_phase_next  = PH_RUN;
            parse_stopped_next = 1'b1;
            stop_position_next = COUNT_W'(1);
          end
        end
        PH_RUN: begin
          run_en = 1'b1;
        end
        default: begin
          run_en = 1'b0;
        end
      endcase
    end

    if (run_en) begin
      active_base_next  = run_base;
      prefix_phase_next = PH_RUN;
      if (!parse_stopped) begin
        if (!digit_in) begin
          parse_stopped_next = 1'b1;
          stop_position_next = char_position;
        end else if (!overflow_seen && run_base != '0) begin
          if (prod[PROD_W-1:VALUE_W] != '0 || sum[VALUE_W]) begin
            overflow_seen_next = 1'b1;
          end else begin
            accumulator_next = sum[VALUE_W-1:0];
          end
        end
      end
    end

    unique case (prefix_phase_next)
      PH_BAD, PH_AUTO:  consumed = '0;
      PH_SAW0, PH_SAW0X: consumed = COUNT_W'(1);
      default: consumed = parse_stopped_next ? stop_position_next : char_position_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      parse_stopped <= 1'b0;
      active_base   <= '0;
      prefix_phase  <= PH_START;
      char_position <= '0;
      stop_position <= '0;
    end else if (go) begin
      if (q_data.last) begin
        accumulator   <= '0;
        overflow_seen <= 1'b0;
        parse_stopped <= 1'b0;
        active_base   <= '0;
        prefix_phase  <= PH_START;
        char_position <= '0;
        stop_position <= '0;
      end else begin
        accumulator   <= accumulator_next;
        overflow_seen <= overflow_seen_next;
        parse_stopped <= parse_stopped_next;
        active_base   <= active_base_next;
        prefix_phase  <= prefix_phase_next;
        char_position <= char_position_next;
        stop_position <= stop_position_next;
      end
    end
  end

  // The finished string waits here; the limit compare runs as the output loads.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (go && q_data.last) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && q_data.last) begin
      fin_acc      <= accumulator_next;
      fin_ovf      <= overflow_seen_next;
      fin_bad      <= (prefix_phase_next == PH_BAD);
      fin_consumed <= consumed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.chars_consumed <= fin_consumed;
      if (fin_bad) begin
        result.parsed_value <= '0;
        result.parse_status <= STATUS_BAD_BASE;
      end else if (fin_ovf || fin_acc > result_limit) begin
        result.parsed_value <= result_limit;
        result.parse_status <= STATUS_RANGE;
      end else begin
        result.parsed_value <= fin_acc;
        result.parse_status <= STATUS_OK;
      end
    end
  end

endmodule

FILE: design/strict_integer_text_parser_core.sv
// Results: a finished string is held in a finish register, then in the output register.
// Throughput: one character word per cycle unless the output stalls, set by the single
// multiply-by-base and add that each digit takes in the back end.
// Reset: synchronous and active high; it empties the queue and output, clears the parse
// state, and sets the base to 10 and the limit to all ones.
module strict_integer_text_parser_core import sitp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  sitp_text_if.sink     text,
  sitp_result_if.source result,
  sitp_cfg_if.sink      cfg
);

  sitp_class_t cls;
  logic        cls_valid;
  logic        cls_ready;
  sitp_class_t q_data;
  logic        q_valid;
  logic        q_pop;

  sitp_front u_front (
    .text      (text),
    .cls       (cls),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready)
  );

  sitp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (cls),
    .push_valid (cls_valid),
    .push_ready (cls_ready),
    .pop_data   (q_data),
    .pop_valid  (q_valid),
    .pop        (q_pop)
  );

  sitp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

FILE: design/sitp_checker.sv
// Port-level checks of the parser core and their binding to it.
module sitp_checker import sitp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                text_ready,
  input logic                result_valid,
  input logic                result_ready,
  input logic [VALUE_W-1:0]  parsed_value,
  input logic [COUNT_W-1:0]  chars_consumed,
  input logic [STATUS_W-1:0] parse_status
);

  // A stalled result word holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(parsed_value)
      && $stable(chars_consumed) && $stable(parse_status))
    else $error("stalled result changed");

  // An invalid base reports neither a value nor consumed characters.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_status == STATUS_BAD_BASE |-> parsed_value == '0
      && chars_consumed == '0)
    else $error("invalid base result carries data");

  // Only the three defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> parse_status == STATUS_OK || parse_status == STATUS_RANGE
      || parse_status == STATUS_BAD_BASE)
    else $error("undefined status code");

  // Reset leaves an empty queue ready to take characters.
  assert property (@(posedge clk) rst |=> text_ready && !result_valid)
    else $error("not ready after reset");

endmodule

bind strict_integer_text_parser_core sitp_checker u_sitp_checker (
  .clk            (clk),
  .rst            (rst),
  .text_ready     (text.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .parsed_value   (result.parsed_value),
  .chars_consumed (result.chars_consumed),
  .parse_status   (result.parse_status)
);

FILE: bench/tb_strict_integer_text_parser_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the strict integer text parser core.
module tb_strict_integer_text_parser_core;
  import sitp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_AUTO,
    SCAN_ZERO,
    SCAN_ZERO_X,
    SCAN_DIGITS,
    SCAN_BAD_BASE
  } scan_phase_e;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  consumed;
    logic [STATUS_W-1:0] status;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst;

  sitp_text_if   text_bus();
  sitp_result_if result_bus();
  sitp_cfg_if    cfg_bus();

  strict_integer_text_parser_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #1 clk = ~clk;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int          err_count = 0;
  logic [BASE_W-1:0] stim_base = BASE_W'(RESET_BASE);
  logic [7:0]        text_buf[$];

  logic [BASE_W-1:0]  base_reg = BASE_W'(RESET_BASE);
  logic [VALUE_W-1:0] limit_reg = '1;
  logic [VALUE_W-1:0] acc_value = '0;
  logic               acc_overflow = 1'b0;
  logic               scan_stopped = 1'b0;
  logic [BASE_W-1:0]  scan_base = '0;
  scan_phase_e        scan_phase = SCAN_START;
  int unsigned        text_pos = 0;
  int unsigned        stop_pos = 0;
  parse_result_t      pending_results[$];

  function automatic int char_digit_value(logic [7:0] c, int unsigned radix);
    int v;
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) v = int'(c - CH_ZERO);
    else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd25) v = int'(c - CH_LOWER_A) + 10;
    else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25) v = int'(c - CH_UPPER_A) + 10;
    else return -1;
    return (v < int'(radix)) ? v : -1;
  endfunction

  function automatic void accumulate_digit(logic [7:0] c);
    int           d;
    logic [127:0] prod;
    logic [64:0]  sum;
    if (scan_stopped) return;
    d = char_digit_value(c, scan_base);
    if (d < 0) begin
      scan_stopped = 1'b1;
      stop_pos = text_pos;
      return;
    end
    if (acc_overflow || scan_base == 0) return;
    prod = 128'(acc_value) * 128'(scan_base);
    if (prod[127:64] != 64'd0) begin
      acc_overflow = 1'b1;
      return;
    end
    sum = {1'b0, prod[63:0]} + 65'(d);
    if (sum[64]) begin
      acc_overflow = 1'b1;
      return;
    end
    acc_value = sum[63:0];
  endfunction

  function automatic void enter_digits(int unsigned radix, logic [7:0] c);
    scan_base = BASE_W'(radix);
    scan_phase = SCAN_DIGITS;
    accumulate_digit(c);
  endfunction

  function automatic void clear_scan();
    acc_value = '0;
    acc_overflow = 1'b0;
    scan_stopped = 1'b0;
    scan_base = '0;
    scan_phase = SCAN_START;
    text_pos = 0;
    stop_pos = 0;
  endfunction

  function automatic void track_text_word(logic [7:0] c, logic has, logic last);
    parse_result_t res;
    if (scan_phase == SCAN_START) begin
      scan_base = base_reg;
      if (base_reg > MAX_BASE) scan_phase = SCAN_BAD_BASE;
      else if (base_reg == 0) scan_phase = SCAN_AUTO;
      else scan_phase = SCAN_DIGITS;
    end
    if (has && text_pos < MAX_TEXT_LENGTH) begin
      case (scan_phase)
        SCAN_AUTO: begin
          if (c == CH_ZERO) scan_phase = SCAN_ZERO;
          else enter_digits(10, c);
        end
        SCAN_ZERO: begin
          if (char_digit_value(c, 8) >= 0) enter_digits(8, c);
          else if (c == CH_LOWER_X) scan_phase = SCAN_ZERO_X;
          else enter_digits(10, c);
        end
        SCAN_ZERO_X: begin
          if (char_digit_value(c, 16) >= 0) begin
            enter_digits(16, c);
          end else begin
            scan_base = BASE_W'(10);
            scan_phase = SCAN_DIGITS;
            scan_stopped = 1'b1;
            stop_pos = 1;
          end
        end
        SCAN_DIGITS: accumulate_digit(c);
        default: ;
      endcase
      text_pos++;
    end
    if (!last) return;
    case (scan_phase)
      SCAN_BAD_BASE, SCAN_AUTO: res.consumed = '0;
      SCAN_ZERO, SCAN_ZERO_X: res.consumed = COUNT_W'(1);
      default: res.consumed = COUNT_W'(scan_stopped ? stop_pos : text_pos);
    endcase
    if (scan_phase == SCAN_BAD_BASE) begin
      res.value = '0;
      res.status = STATUS_BAD_BASE;
    end else if (acc_overflow || acc_value > limit_reg) begin
      res.value = limit_reg;
      res.status = STATUS_RANGE;
    end else begin
      res.value = acc_value;
      res.status = STATUS_OK;
    end
    pending_results.push_back(res);
    clear_scan();
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_NUMBER_BASE: base_reg = cfg_bus.data[BASE_W-1:0];
          CFG_RESULT_LIMIT: limit_reg = cfg_bus.data;
          default: ;
        endcase
      end
      if (text_bus.valid && text_bus.ready) begin
        track_text_word(text_bus.character, text_bus.has_char, text_bus.end_of_text);
      end
    end
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no string pending", result_bus.parsed_value));
      end else begin
        want = pending_results.pop_front();
        if (result_bus.parsed_value !== want.value)
          report_mismatch($sformatf("parsed_value %h, expected %h",
                                    result_bus.parsed_value, want.value));
        if (result_bus.chars_consumed !== want.consumed)
          report_mismatch($sformatf("chars_consumed %0d, expected %0d",
                                    result_bus.chars_consumed, want.consumed));
        if (result_bus.parse_status !== want.status)
          report_mismatch($sformatf("parse_status %0d, expected %0d",
                                    result_bus.parse_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_bus.valid && text_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic [7:0] c, input logic has, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      text_bus.valid <= 1'b0;
      @(negedge clk);
    end
    text_bus.valid <= 1'b1;
    text_bus.character <= c;
    text_bus.has_char <= has;
    text_bus.end_of_text <= last;
    do @(posedge clk); while (!text_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_text_buf(input bit with_fillers);
    int n;
    bit close_apart;
    n = text_buf.size();
    close_apart = (n == 0) || (with_fillers && $urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      if (with_fillers && $urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(text_buf[i], 1'b1, !close_apart && i == n - 1);
    end
    if (close_apart) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_str(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text_buf(1'b0);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= d;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    text_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [BASE_W-1:0] base, input logic [VALUE_W-1:0] limit);
    wait_drained();
    stim_base = base;
    cfg_write(CFG_NUMBER_BASE, ({$urandom, $urandom} & ~64'h3F) | 64'(base));
    cfg_write(CFG_RESULT_LIMIT, limit);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(int unsigned v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_limit(int k, int mode);
    case (k)
      0: return '1;
      1: return {$urandom, $urandom};
      2: return 64'($urandom_range(5000));
      default: return (mode % 2 == 0) ? 64'd0 : ({$urandom, $urandom} >> $urandom_range(63));
    endcase
  endfunction

  function automatic void make_text(logic [BASE_W-1:0] base);
    int unsigned kind;
    int unsigned radix;
    int unsigned len;
    text_buf.delete();
    kind = $urandom_range(99);
    if (kind < 10) begin
      len = $urandom_range(6);
      repeat (len) text_buf.push_back(8'($urandom));
      return;
    end
    radix = (base > MAX_BASE) ? 36 : base;
    if (base == 0) begin
      case ($urandom_range(2))
        0: begin
          radix = 8;
          text_buf.push_back(CH_ZERO);
        end
        1: begin
          radix = 16;
          text_buf.push_back(CH_ZERO);
          text_buf.push_back($urandom_range(7) == 0 ? CH_UPPER_X : CH_LOWER_X);
        end
        default: radix = 10;
      endcase
    end
    if ($urandom_range(15) == 0) len = $urandom_range(60, 70);
    else if ($urandom_range(3) == 0) len = $urandom_range(12, 24);
    else len = $urandom_range(1, 8);
    repeat (len) text_buf.push_back(digit_char($urandom_range(radix - 1)));
    if (kind < 30) begin
      text_buf.push_back((radix < 36 && $urandom_range(1)) ?
                         digit_char($urandom_range(35, radix)) : 8'($urandom));
      repeat ($urandom_range(3)) text_buf.push_back(8'($urandom));
    end
  endfunction

  task automatic test_reset_defaults();
    send_str("7");
    send_str("");
    send_word(CH_ZERO + 8'd1, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(CH_ZERO + 8'd2, 1'b1, 1'b1);
    send_str("4z9");
  endtask

  task automatic test_overflow_and_limit();
    set_config(6'd36, '1);
    send_str("3w5E11264sGsg");
    set_config(6'd10, 64'd100);
    send_str("101");
    send_str("100");
    set_config(6'd2, 64'd0);
    send_str("0");
    send_str("1");
  endtask

  task automatic test_radix_extremes();
    set_config(6'd37, '1);
    send_str("5");
    set_config(6'd63, '1);
    send_str("");
    set_config(6'd1, '1);
    send_str("01");
  endtask

  task automatic test_auto_prefix();
    set_config(6'd0, '1);
    send_str("0");
    send_str("0x");
    send_str("017");
    send_str("0x1F");
    send_str("0X5");
    send_str("0xg");
    send_str("9");
  endtask

  task automatic test_random_traffic();
    logic [BASE_W-1:0] bases [16] = '{10, 0, 36, 2, 16, 1, 0, 37, 8, 0, 63, 36, 10, 0, 3, 0};
    int sent;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        set_config((mode == 3 && k == 2) ? BASE_W'($urandom_range(63)) : bases[mode * 4 + k],
                   pick_limit(k, mode));
        sent = 0;
        while (sent < 60) begin
          make_text(stim_base);
          send_text_buf(1'b1);
          sent += text_buf.size() + 1;
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_long_text();
    set_config(6'd10, '1);
    for (int i = 0; i < 40; i++) send_word(CH_ZERO, 1'b1, 1'b0);
    send_word(CH_ZERO + 8'd5, 1'b1, 1'b0);
    send_word(CH_LOWER_A + 8'd25, 1'b1, 1'b1);
  endtask

  initial begin
    text_bus.valid = 1'b0;
    text_bus.character = '0;
    text_bus.has_char = 1'b0;
    text_bus.end_of_text = 1'b0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_NUMBER_BASE;
    cfg_bus.data = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_overflow_and_limit();
    test_radix_extremes();
    test_auto_prefix();
    test_random_traffic();
    test_long_text();
    wait_drained();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
